// ===== rtl/core/trims_pkg.sv =====
`default_nettype none
package trims_pkg;

   localparam int unsigned NumVerts      = 6;
   localparam int unsigned CornersPerTri = 3;

   typedef struct packed {
      logic start;
   } norm_ctl_type;

   typedef struct packed {
      logic done;
   } norm_stat_type;

   // corner of one index triangle of the four-way split, as a vertex offset
   function automatic logic [2:0] tri_corner(input logic [1:0] tri_sel,
                                             input logic [1:0] slot);
      logic [8:0] row;
      row = 9'd0;
      case (tri_sel)
         2'd0: row = {3'd0, 3'd3, 3'd4};
         2'd1: row = {3'd3, 3'd1, 3'd5};
         2'd2: row = {3'd5, 3'd2, 3'd4};
         default: row = {3'd3, 3'd5, 3'd4};
      endcase
      case (slot)
         2'd0: return row[8:6];
         2'd1: return row[5:3];
         default: return row[2:0];
      endcase
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/trims_req_if.sv =====
`default_nettype none
interface trims_req_if #(
   parameter int COORD_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] in_pos_x;
   logic signed [COORD_BITS-1:0] in_pos_y;
   logic signed [COORD_BITS-1:0] in_pos_z;
   logic        [COORD_BITS-1:0] in_tex_u;
   logic        [COORD_BITS-1:0] in_tex_v;

   modport source (output valid, in_pos_x, in_pos_y, in_pos_z, in_tex_u, in_tex_v,
                   input ready);
   modport sink (input valid, in_pos_x, in_pos_y, in_pos_z, in_tex_u, in_tex_v,
                 output ready);
endinterface
`default_nettype wire

// ===== rtl/core/trims_rsp_if.sv =====
`default_nettype none
interface trims_rsp_if #(
   parameter int COORD_BITS = 16,
   parameter int INDEX_BITS = 32
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] out_pos_x;
   logic signed [COORD_BITS-1:0] out_pos_y;
   logic signed [COORD_BITS-1:0] out_pos_z;
   logic        [COORD_BITS-1:0] out_tex_u;
   logic        [COORD_BITS-1:0] out_tex_v;
   logic                         tri_valid;
   logic        [INDEX_BITS-1:0] tri_first;
   logic        [INDEX_BITS-1:0] tri_second;
   logic        [INDEX_BITS-1:0] tri_third;
   logic                         run_last;

   modport source (output valid, out_pos_x, out_pos_y, out_pos_z, out_tex_u, out_tex_v,
                   tri_valid, tri_first, tri_second, tri_third, run_last,
                   input ready);
   modport sink (input valid, out_pos_x, out_pos_y, out_pos_z, out_tex_u, out_tex_v,
                 tri_valid, tri_first, tri_second, tri_third, run_last,
                 output ready);
endinterface
`default_nettype wire

// ===== rtl/core/triangle_midpoint_subdivider.sv =====
`default_nettype none
// channel   direction  carries
// req_item  in         one triangle corner: position, texture coordinate
// rsp_item  out        one vertex, plus an index triangle on vertices three to six
// csr_*     in         sphere projection enable
//
// The first and second corner of a triangle are only stored. The third corner starts
// six vertices; in sphere mode each makes one pass through the shared normalizer:
// normalizing shifts, three multiplies, the square-root steps, three divisions and
// a done state. Reset is synchronous; the output register holds a vertex until taken
// and stalls the sequencer meanwhile.
module triangle_midpoint_subdivider #(
   parameter int COORD_BITS = 16,
   parameter int INDEX_BITS = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   trims_req_if.sink   req_item,
   trims_rsp_if.source rsp_item,
   input  wire logic csr_wr_en,
   input  wire logic csr_wr_data
);

   localparam int CB = COORD_BITS;
   localparam int IB = INDEX_BITS;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_START = 2'd1;
   localparam logic [1:0] S_WAIT  = 2'd2;
   localparam logic [1:0] S_LOAD  = 2'd3;

   typedef struct packed {
      logic signed [CB-1:0] x;
      logic signed [CB-1:0] y;
      logic signed [CB-1:0] z;
      logic [CB-1:0]        u;
      logic [CB-1:0]        v;
   } vtx_type;

   function automatic vtx_type mid(input vtx_type a, input vtx_type b);
      vtx_type            m;
      logic signed [CB:0] sx, sy, sz;
      logic [CB:0]        su, sv;
      sx  = {a.x[CB-1], a.x} + {b.x[CB-1], b.x};
      sy  = {a.y[CB-1], a.y} + {b.y[CB-1], b.y};
      sz  = {a.z[CB-1], a.z} + {b.z[CB-1], b.z};
      su  = {1'b0, a.u} + {1'b0, b.u};
      sv  = {1'b0, a.v} + {1'b0, b.v};
      m.x = sx[CB:1];
      m.y = sy[CB:1];
      m.z = sz[CB:1];
      m.u = su[CB:1];
      m.v = sv[CB:1];
      return m;
   endfunction

   logic [1:0]           state_ff, state_in;
   logic [1:0]           cnt_ff, cnt_in;
   logic [2:0]           k_ff, k_in;
   logic [IB-1:0]        base_ff, base_in;
   logic                 mode_ff, mode_in;
   logic                 run_mode_ff, run_mode_in;
   vtx_type              c0_ff, c1_ff, c2_ff;
   logic signed [CB-1:0] px_ff, py_ff, pz_ff;
   logic signed [CB-1:0] px_in, py_in, pz_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [CB-1:0] o_px_ff, o_py_ff, o_pz_ff;
   logic [CB-1:0]        o_u_ff, o_v_ff;
   logic                 o_tri_ff, o_last_ff;
   logic [IB-1:0]        o_first_ff, o_second_ff, o_third_ff;

   vtx_type                  cur, vsel;
   logic                     take, load;
   logic [1:0]               tsel;
   trims_pkg::norm_ctl_type  nctl;
   trims_pkg::norm_stat_type nstat;
   logic signed [CB-1:0]     nx, ny, nz;

   trims_norm #(
      .COORD_BITS(COORD_BITS)
   ) u_norm (
      .clock (clock),
      .reset (reset),
      .ctl   (nctl),
      .in_x  (vsel.x),
      .in_y  (vsel.y),
      .in_z  (vsel.z),
      .stat  (nstat),
      .out_x (nx),
      .out_y (ny),
      .out_z (nz)
   );

   always_comb begin
      cur.x = req_item.in_pos_x;
      cur.y = req_item.in_pos_y;
      cur.z = req_item.in_pos_z;
      cur.u = req_item.in_tex_u;
      cur.v = req_item.in_tex_v;
      case (k_ff)
         3'd0: vsel = c0_ff;
         3'd1: vsel = c1_ff;
         3'd2: vsel = c2_ff;
         3'd3: vsel = mid(c0_ff, c1_ff);
         3'd4: vsel = mid(c0_ff, c2_ff);
         3'd5: vsel = mid(c1_ff, c2_ff);
         default: vsel = c0_ff;
      endcase
      tsel = 2'(k_ff - 3'(trims_pkg::CornersPerTri - 1));
   end

   assign req_item.ready = state_ff == S_IDLE;
   assign take = req_item.valid && req_item.ready;
   assign load = (state_ff == S_LOAD) && (!rsp_valid_ff || rsp_item.ready);
   assign nctl.start = (state_ff == S_START) && run_mode_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      base_in      = base_ff;
      run_mode_in  = run_mode_ff;
      mode_in      = csr_wr_en ? csr_wr_data : mode_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      pz_in        = pz_ff;
      rsp_valid_in = load ? 1'b1 : (rsp_item.ready ? 1'b0 : rsp_valid_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               if (cnt_ff == 2'(trims_pkg::CornersPerTri - 1)) begin
                  cnt_in      = 2'd0;
                  k_in        = 3'd0;
                  run_mode_in = mode_ff;
                  state_in    = S_START;
               end else begin
                  cnt_in = cnt_ff + 2'd1;
               end
            end
         end
         S_START: begin
            if (run_mode_ff) begin
               state_in = S_WAIT;
            end else begin
               px_in    = vsel.x;
               py_in    = vsel.y;
               pz_in    = vsel.z;
               state_in = S_LOAD;
            end
         end
         S_WAIT: begin
            if (nstat.done) begin
               px_in    = nx;
               py_in    = ny;
               pz_in    = nz;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            if (load) begin
               if (k_ff == 3'(trims_pkg::NumVerts - 1)) begin
                  base_in  = base_ff + IB'(trims_pkg::NumVerts);
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + 3'd1;
                  state_in = S_START;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= 2'd0;
         k_ff         <= 3'd0;
         base_ff      <= '0;
         mode_ff      <= 1'b1;
         run_mode_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         k_ff         <= k_in;
         base_ff      <= base_in;
         mode_ff      <= mode_in;
         run_mode_ff  <= run_mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff <= px_in;
      py_ff <= py_in;
      pz_ff <= pz_in;
      if (take) begin
         unique case (cnt_ff)
            2'd0: c0_ff <= cur;
            2'd1: c1_ff <= cur;
            default: c2_ff <= cur;
         endcase
      end
      if (load) begin
         o_px_ff   <= px_ff;
         o_py_ff   <= py_ff;
         o_pz_ff   <= pz_ff;
         o_u_ff    <= vsel.u;
         o_v_ff    <= vsel.v;
         o_last_ff <= k_ff == 3'(trims_pkg::NumVerts - 1);
         if (k_ff >= 3'(trims_pkg::CornersPerTri - 1)) begin
            o_tri_ff    <= 1'b1;
            o_first_ff  <= base_ff + IB'(trims_pkg::tri_corner(tsel, 2'd0));
            o_second_ff <= base_ff + IB'(trims_pkg::tri_corner(tsel, 2'd1));
            o_third_ff  <= base_ff + IB'(trims_pkg::tri_corner(tsel, 2'd2));
         end else begin
            o_tri_ff    <= 1'b0;
            o_first_ff  <= '0;
            o_second_ff <= '0;
            o_third_ff  <= '0;
         end
      end
   end

   assign rsp_item.valid      = rsp_valid_ff;
   assign rsp_item.out_pos_x  = o_px_ff;
   assign rsp_item.out_pos_y  = o_py_ff;
   assign rsp_item.out_pos_z  = o_pz_ff;
   assign rsp_item.out_tex_u  = o_u_ff;
   assign rsp_item.out_tex_v  = o_v_ff;
   assign rsp_item.tri_valid  = o_tri_ff;
   assign rsp_item.tri_first  = o_first_ff;
   assign rsp_item.tri_second = o_second_ff;
   assign rsp_item.tri_third  = o_third_ff;
   assign rsp_item.run_last   = o_last_ff;

endmodule
`default_nettype wire

// ===== rtl/core/trims_norm.sv =====
`default_nettype none
module trims_norm #(
   parameter int COORD_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire trims_pkg::norm_ctl_type      ctl,
   input  wire logic signed [COORD_BITS-1:0] in_x,
   input  wire logic signed [COORD_BITS-1:0] in_y,
   input  wire logic signed [COORD_BITS-1:0] in_z,
   output trims_pkg::norm_stat_type          stat,
   output logic signed [COORD_BITS-1:0]      out_x,
   output logic signed [COORD_BITS-1:0]      out_y,
   output logic signed [COORD_BITS-1:0]      out_z
);

   localparam int CB      = COORD_BITS;
   localparam int NormBit = 29;
   localparam int MAGW    = (CB > NormBit + 1) ? CB : NormBit + 1;
   localparam int SW      = 2 * MAGW + 2;
   localparam int DW      = MAGW + CB - 2;
   localparam int QB      = CB - 3;
   localparam int CW      = $clog2(SW / 2 + 1);

   localparam logic [2:0] N_IDLE  = 3'd0;
   localparam logic [2:0] N_SHIFT = 3'd1;
   localparam logic [2:0] N_SQ    = 3'd2;
   localparam logic [2:0] N_ROOT  = 3'd3;
   localparam logic [2:0] N_DIVI  = 3'd4;
   localparam logic [2:0] N_DIV   = 3'd5;
   localparam logic [2:0] N_DONE  = 3'd6;

   logic [2:0]           state_ff, state_in;
   logic [MAGW-1:0]      mag_ff [3];
   logic [MAGW-1:0]      mag_in [3];
   logic                 neg_ff [3];
   logic                 neg_in [3];
   logic signed [CB-1:0] res_ff [3];
   logic signed [CB-1:0] res_in [3];
   logic [SW-1:0]        acc_ff, acc_in;
   logic [SW-1:0]        root_ff, root_in;
   logic [SW-1:0]        bit_ff, bit_in;
   logic [DW-1:0]        rem_ff, rem_in;
   logic [DW-1:0]        dsr_ff, dsr_in;
   logic [QB-1:0]        q_ff, q_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [1:0]           idx_ff, idx_in;

   logic signed [CB:0]   ext [3];
   logic [CB:0]          absv [3];
   logic [MAGW-1:0]      mag_or;
   logic [SW-1:0]        trial;
   logic                 ge;
   logic signed [CB-1:0] qx;

   always_comb begin
      ext[0] = {in_x[CB-1], in_x};
      ext[1] = {in_y[CB-1], in_y};
      ext[2] = {in_z[CB-1], in_z};
      for (int i = 0; i < 3; i++) begin
         absv[i] = ext[i][CB] ? unsigned'(-ext[i]) : unsigned'(ext[i]);
      end
      mag_or = mag_ff[0] | mag_ff[1] | mag_ff[2];
      trial  = root_ff + bit_ff;
      ge     = rem_ff >= dsr_ff;
      q_in   = {q_ff[QB-2:0], ge};
      qx     = signed'(CB'(q_in));

      state_in = state_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      res_in   = res_ff;
      acc_in   = acc_ff;
      root_in  = root_ff;
      bit_in   = bit_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;

      unique case (state_ff)
         N_IDLE: begin
            if (ctl.start) begin
               for (int i = 0; i < 3; i++) begin
                  mag_in[i] = MAGW'(absv[i][CB-1:0]);
                  neg_in[i] = ext[i][CB];
               end
               res_in[0] = in_x;
               res_in[1] = in_y;
               res_in[2] = in_z;
               if (in_x == '0 && in_y == '0 && in_z == '0) begin
                  state_in = N_DONE;
               end else begin
                  state_in = N_SHIFT;
               end
            end
         end
         N_SHIFT: begin
            if (mag_or[MAGW-1:NormBit] == '0) begin
               for (int i = 0; i < 3; i++) begin
                  mag_in[i] = mag_ff[i] << 1;
               end
            end else begin
               acc_in   = '0;
               idx_in   = 2'd0;
               state_in = N_SQ;
            end
         end
         N_SQ: begin
            acc_in = acc_ff + SW'(mag_ff[idx_ff] * mag_ff[idx_ff]);
            if (idx_ff == 2'd2) begin
               root_in  = '0;
               bit_in   = SW'(1) << (SW - 2);
               cnt_in   = CW'(SW / 2);
               state_in = N_ROOT;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
         N_ROOT: begin
            if (acc_ff >= trial) begin
               acc_in  = acc_ff - trial;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               idx_in   = 2'd0;
               state_in = N_DIVI;
            end
         end
         N_DIVI: begin
            rem_in   = (DW'(mag_ff[idx_ff]) << (CB - 4)) + DW'(root_ff >> 1);
            dsr_in   = DW'(root_ff) << (QB - 1);
            q_in     = '0;
            cnt_in   = CW'(QB);
            state_in = N_DIV;
         end
         N_DIV: begin
            if (ge) begin
               rem_in = rem_ff - dsr_ff;
            end
            dsr_in = dsr_ff >> 1;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               res_in[idx_ff] = neg_ff[idx_ff] ? -qx : qx;
               if (idx_ff == 2'd2) begin
                  state_in = N_DONE;
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  state_in = N_DIVI;
               end
            end
         end
         N_DONE: begin
            state_in = N_IDLE;
         end
         default: begin
            state_in = N_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      res_ff  <= res_in;
      acc_ff  <= acc_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      cnt_ff  <= cnt_in;
      idx_ff  <= idx_in;
      q_ff    <= (state_ff == N_DIVI) ? '0 : q_in;
   end

   assign stat.done = state_ff == N_DONE;
   assign out_x     = res_ff[0];
   assign out_y     = res_ff[1];
   assign out_z     = res_ff[2];

endmodule
`default_nettype wire

// ===== bench/trims_scoreboard.sv =====
`timescale 1ns / 100ps
module trims_scoreboard (
   input  wire logic clock,
   input  wire logic reset,
   trims_req_if      req,
   trims_rsp_if      rsp,
   input  wire logic csr_wr_en,
   input  wire logic csr_wr_data,
   output int        fail_count,
   output int        pending,
   output int        vertex_count,
   output int        corner_count
);

   typedef struct {
      logic signed [15:0] px, py, pz;
      logic        [15:0] tu, tv;
      logic               tv_ok;
      logic        [31:0] i0, i1, i2;
      logic               last;
   } vertex_type;

   vertex_type         exp_vertices[$];
   logic               sphere_mode;
   logic         [1:0] held;
   logic signed [15:0] held_pos[2][3];
   logic        [15:0] held_tex[2][2];
   logic        [31:0] base;

   assign pending = exp_vertices.size();

   function automatic vertex_type to_unit(vertex_type v);
      longint unsigned m[3];
      longint unsigned mx, s, r, bitv, len, q;
      logic signed [15:0] c[3];
      logic signed [15:0] o;
      c[0] = v.px;
      c[1] = v.py;
      c[2] = v.pz;
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = (c[i] < 0) ? longint'(-longint'(c[i])) : longint'(c[i]);
         if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) return v;
      while (mx < (64'd1 << 29)) begin
         mx = mx << 1;
         for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      end
      s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (s >= r + bitv) begin
            s = s - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      len = r;
      for (int i = 0; i < 3; i++) begin
         q = (m[i] * 64'd4096 + len / 2) / len;
         if (q > 64'd32767) q = 64'd32767;
         o = q[15:0];
         c[i] = (c[i] < 0) ? -o : o;
      end
      v.px = c[0];
      v.py = c[1];
      v.pz = c[2];
      return v;
   endfunction

   task automatic report(string field, longint unsigned e, longint unsigned a);
      $display("%0t: %s expected %0h actual %0h", $time, field, e, a);
      fail_count++;
   endtask

   function automatic vertex_type make_vertex(logic signed [15:0] p[3], logic [15:0] t[2]);
      vertex_type v;
      v.px = p[0];
      v.py = p[1];
      v.pz = p[2];
      v.tu = t[0];
      v.tv = t[1];
      v.tv_ok = 1'b0;
      v.i0 = '0;
      v.i1 = '0;
      v.i2 = '0;
      v.last = 1'b0;
      return v;
   endfunction

   always @(posedge clock) begin
      vertex_type v[6];
      vertex_type e;
      logic signed [15:0] p[3][3];
      logic        [15:0] t[3][2];
      logic signed [16:0] ps;
      logic        [16:0] ts;
      logic        [31:0] pat[4][3];
      if (reset) begin
         sphere_mode  <= 1'b1;
         held         <= '0;
         base         <= '0;
         fail_count   = 0;
         vertex_count = 0;
         corner_count = 0;
         exp_vertices.delete();
      end else begin
         if (csr_wr_en) sphere_mode <= csr_wr_data;
         if (rsp.valid && rsp.ready) begin
            vertex_count++;
            if (exp_vertices.size() == 0) begin
               $display("%0t: unexpected vertex, expected none actual %0h %0h %0h", $time,
                        rsp.out_pos_x, rsp.out_pos_y, rsp.out_pos_z);
               fail_count++;
            end else begin
               e = exp_vertices.pop_front();
               if (rsp.out_pos_x !== e.px) report("out_pos_x", e.px, rsp.out_pos_x);
               if (rsp.out_pos_y !== e.py) report("out_pos_y", e.py, rsp.out_pos_y);
               if (rsp.out_pos_z !== e.pz) report("out_pos_z", e.pz, rsp.out_pos_z);
               if (rsp.out_tex_u !== e.tu) report("out_tex_u", e.tu, rsp.out_tex_u);
               if (rsp.out_tex_v !== e.tv) report("out_tex_v", e.tv, rsp.out_tex_v);
               if (rsp.tri_valid !== e.tv_ok) report("tri_valid", e.tv_ok, rsp.tri_valid);
               if (rsp.tri_first !== e.i0) report("tri_first", e.i0, rsp.tri_first);
               if (rsp.tri_second !== e.i1) report("tri_second", e.i1, rsp.tri_second);
               if (rsp.tri_third !== e.i2) report("tri_third", e.i2, rsp.tri_third);
               if (rsp.run_last !== e.last) report("run_last", e.last, rsp.run_last);
            end
         end
         if (req.valid && req.ready) begin
            corner_count++;
            if (held < 2) begin
               held_pos[held[0]][0] <= req.in_pos_x;
               held_pos[held[0]][1] <= req.in_pos_y;
               held_pos[held[0]][2] <= req.in_pos_z;
               held_tex[held[0]][0] <= req.in_tex_u;
               held_tex[held[0]][1] <= req.in_tex_v;
               held <= held + 2'd1;
            end else begin
               held <= '0;
               for (int a = 0; a < 2; a++) begin
                  for (int j = 0; j < 3; j++) p[a][j] = held_pos[a][j];
                  for (int j = 0; j < 2; j++) t[a][j] = held_tex[a][j];
               end
               p[2][0] = req.in_pos_x;
               p[2][1] = req.in_pos_y;
               p[2][2] = req.in_pos_z;
               t[2][0] = req.in_tex_u;
               t[2][1] = req.in_tex_v;
               for (int k = 0; k < 3; k++) v[k] = make_vertex(p[k], t[k]);
               for (int k = 3; k < 6; k++) begin
                  int a, b;
                  logic signed [15:0] mp[3];
                  logic        [15:0] mt[2];
                  a = (k == 5) ? 1 : 0;
                  b = (k == 3) ? 1 : 2;
                  for (int j = 0; j < 3; j++) begin
                     ps = {p[a][j][15], p[a][j]} + {p[b][j][15], p[b][j]};
                     mp[j] = ps[16:1];
                  end
                  for (int j = 0; j < 2; j++) begin
                     ts = {1'b0, t[a][j]} + {1'b0, t[b][j]};
                     mt[j] = ts[16:1];
                  end
                  v[k] = make_vertex(mp, mt);
               end
               pat = '{'{0, 3, 4}, '{3, 1, 5}, '{5, 2, 4}, '{3, 5, 4}};
               for (int k = 0; k < 6; k++) begin
                  if (sphere_mode) v[k] = to_unit(v[k]);
                  if (k >= 2) begin
                     v[k].tv_ok = 1'b1;
                     v[k].i0 = base + pat[k-2][0];
                     v[k].i1 = base + pat[k-2][1];
                     v[k].i2 = base + pat[k-2][2];
                  end
                  v[k].last = (k == 5);
                  exp_vertices.insert(exp_vertices.size(), v[k]);
               end
               base <= base + 32'd6;
            end
         end
      end
   end

endmodule

// ===== bench/tb_triangle_midpoint_subdivider.sv =====
`timescale 1ns / 100ps
module tb_triangle_midpoint_subdivider;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;
   logic quiet;
   int   fail_count, pending, vertex_count, corner_count;
   int   idle_cycles;
   int   stall_left;

   trims_req_if #(.COORD_BITS(16)) req ();
   trims_rsp_if #(.COORD_BITS(16), .INDEX_BITS(32)) rsp ();

   triangle_midpoint_subdivider u_top (
      .clock       (clock),
      .reset       (reset),
      .req_item    (req),
      .rsp_item    (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   trims_scoreboard u_scoreboard (
      .clock        (clock),
      .reset        (reset),
      .req          (req),
      .rsp          (rsp),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .fail_count   (fail_count),
      .pending      (pending),
      .vertex_count (vertex_count),
      .corner_count (corner_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_wr_data  = 1'b0;
      quiet        = 1'b0;
      req.valid    = 1'b0;
      req.in_pos_x = '0;
      req.in_pos_y = '0;
      req.in_pos_z = '0;
      req.in_tex_u = '0;
      req.in_tex_v = '0;
      rsp.ready    = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= 20000) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         stall_left <= 0;
         rsp.ready  <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp.ready  <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 2);
         rsp.ready  <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   task automatic send_corner(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                              logic [15:0] u, logic [15:0] v);
      logic ok;
      req.valid    <= 1'b1;
      req.in_pos_x <= x;
      req.in_pos_y <= y;
      req.in_pos_z <= z;
      req.in_tex_u <= u;
      req.in_tex_v <= v;
      do begin
         #1;
         ok = req.ready;
         @(posedge clock);
      end while (!ok);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic write_mode(logic mode);
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic directed_set();
      send_corner(16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
      send_corner(16'h7fff, 16'h7fff, 16'h7fff, 16'hffff, 16'hffff);
      send_corner(16'h0000, 16'h0000, 16'h0000, 16'hffff, 16'h0000);
      send_corner(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hffff);
      send_corner(16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000);
      send_corner(16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0001);
      send_corner(16'h0001, 16'h0000, 16'h0000, 16'h0001, 16'h0002);
      send_corner(16'hffff, 16'h0000, 16'h0000, 16'h0003, 16'h0004);
      send_corner(16'h7fff, 16'h8000, 16'h0001, 16'hfffe, 16'h0001);
   endtask

   task automatic random_triangle();
      logic [15:0] f[5];
      for (int c = 0; c < 3; c++) begin
         for (int j = 0; j < 5; j++) begin
            f[j] = 16'($urandom);
            if (j < 3 && $urandom_range(0, 4) == 0) f[j] = $signed(f[j]) >>> $urandom_range(4, 15);
         end
         send_corner(f[0], f[1], f[2], f[3], f[4]);
      end
   endtask

   initial begin
      idle_cycles = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_set();
      write_mode(1'b0);
      directed_set();
      send_corner(16'h1000, 16'h2000, 16'h3000, 16'h1111, 16'h2222);
      write_mode(1'b1);
      send_corner(16'hf000, 16'h0800, 16'h0400, 16'h3333, 16'h4444);
      send_corner(16'h0100, 16'hff00, 16'h2000, 16'h5555, 16'h6666);
      for (int n = 0; n < 83; n++) begin
         if (n == 30) write_mode(1'b0);
         if (n == 55) write_mode(1'b1);
         if (n == 70) quiet = 1'b1;
         random_triangle();
      end
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("Covered %0d corners and %0d vertices in both projection modes,",
               corner_count, vertex_count);
      $display("including extreme, zero and random triangles with output stalls.");
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
